FILE: rtl/smt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// Types and constants shared by the sorted multiset table modules.
// ----------------------------------------------------------------------------
package smt_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      ACT_SEARCH = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

endpackage : smt_pkg
`default_nettype wire

FILE: rtl/smt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_ctrl
// Command sequencer: takes a request word, fires the table update when the
// result register is free, and owns the response valid flag.
// ----------------------------------------------------------------------------
module smt_ctrl
   import smt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output dp_cmd_type      dp_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.exec = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (dp_cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : smt_ctrl
`default_nettype wire

FILE: rtl/smt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_dp
// Cell array datapath: each cell compares against the command value; the
// cells from the insert point shift right on insert, or left on remove.
// ----------------------------------------------------------------------------
module smt_dp
   import smt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                dp_cmd,
   input  wire logic [1:0]                req_action,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_found,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_count
);

   logic signed [VALUE_W-1:0] cell_ff [DEPTH];
   logic signed [VALUE_W-1:0] ins_in  [DEPTH];
   logic signed [VALUE_W-1:0] rem_in  [DEPTH];
   logic [CNT_W-1:0]          count_ff, count_in;
   action_type                action_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      found_ff, found_in;
   status_type                status_ff, status_in;
   logic [DEPTH-1:0]          lt, eq;
   logic                      any_eq, full;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      logic live;
      assign live  = CNT_W'(i) < count_ff;
      assign lt[i] = live && (cell_ff[i] < value_ff);
      assign eq[i] = live && (cell_ff[i] == value_ff);
   end

   // lt is a prefix of the sorted row: its first clear bit is the
   // insert point and also the first equal entry, if any.
   for (genvar i = 0; i < DEPTH; i++) begin : g_shift
      if (i == 0) begin : g_head
         assign ins_in[i] = lt[i] ? cell_ff[i] : value_ff;
      end else begin : g_body
         assign ins_in[i] = lt[i] ? cell_ff[i] : (lt[i-1] ? value_ff : cell_ff[i-1]);
      end
      if (i == DEPTH - 1) begin : g_tail
         assign rem_in[i] = cell_ff[i];
      end else begin : g_mid
         assign rem_in[i] = lt[i] ? cell_ff[i] : cell_ff[i+1];
      end
   end

   assign any_eq = |eq;
   assign full   = count_ff == CNT_W'(DEPTH);

   always_comb begin
      count_in  = count_ff;
      found_in  = 1'b0;
      status_in = STS_OK;
      case (action_ff)
         ACT_SEARCH: found_in = any_eq;
         ACT_INSERT: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (any_eq) begin
               found_in = 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = STS_NOT_FOUND;
            end
         end
         ACT_CLEAR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         action_ff <= action_type'(req_action);
         value_ff  <= req_value;
      end
      if (dp_cmd.exec) begin
         found_ff  <= found_in;
         status_ff <= status_in;
         if (action_ff == ACT_INSERT && !full) begin
            for (int i = 0; i < DEPTH; i++) cell_ff[i] <= ins_in[i];
         end else if (action_ff == ACT_REMOVE && any_eq) begin
            for (int i = 0; i < DEPTH; i++) cell_ff[i] <= rem_in[i];
         end
      end
   end

   assign rsp_found  = found_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = COUNT_W'(count_ff);

endmodule : smt_dp
`default_nettype wire

FILE: rtl/sorted_multiset_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_table
// Ascending table of signed 32-bit values with duplicates, driven by
// search, insert, remove-first-match and clear commands.
// ----------------------------------------------------------------------------
// Each request word yields one response word. A command is first accepted,
// loading the action and value registers; then every cell compares against the
// value in parallel and the cell row shifts to insert or remove, loading the
// response register. No new request is taken until that update is done; a new
// request is taken while the previous response still waits, and the update
// is held only while that response is not yet taken.
module sorted_multiset_table
   import smt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_found,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_count
);

   dp_cmd_type dp_cmd;

   smt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   smt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_FULL |-> rsp_count == COUNT_W'(DEPTH))
      else $error("full status with count below depth");

   a_miss_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_NOT_FOUND |-> !rsp_found)
      else $error("not-found status with found set");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STS_OK)
      else $error("found with error status");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is pending");

endmodule : sorted_multiset_table
`default_nettype wire
